// ===== sv/erfd_pkg.sv =====
// Shared types and constants of the response frame decoder.
// Used by the front, queue, back and top modules; depends on nothing.
`timescale 1ns / 1ps

package erfd_pkg;

  localparam int unsigned MAX_FRAME = 128;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned NUM_CAP   = 13;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned OUT_W     = 112;

  localparam logic [CNT_W-1:0] MAX_FRAME_C  = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] MIN_LEN      = CNT_W'(5);
  localparam logic [CNT_W-1:0] ACK_MIN_LEN  = CNT_W'(9);
  localparam logic [CNT_W-1:0] DATA_MIN_LEN = CNT_W'(49);
  localparam logic [CNT_W-1:0] DSUM_FIRST   = CNT_W'(6);
  localparam logic [CNT_W-1:0] DSUM_END     = CNT_W'(48);
  localparam logic [7:0]       ACK_BYTE     = 8'hC1;
  localparam logic [7:0]       TEMP_OFFSET  = 8'h28;

  // Slots of the captured byte array.
  localparam int unsigned CAP_ACK    = 0;
  localparam int unsigned CAP_TEMP   = 1;
  localparam int unsigned CAP_THR    = 2;
  localparam int unsigned CAP_LOAD   = 3;
  localparam int unsigned CAP_IDLE   = 4;
  localparam int unsigned CAP_VALVE  = 5;
  localparam int unsigned CAP_BATT   = 6;
  localparam int unsigned CAP_LAMBDA = 7;
  localparam int unsigned CAP_INJ_LO = 8;
  localparam int unsigned CAP_INJ_HI = 9;
  localparam int unsigned CAP_AIR_LO = 10;
  localparam int unsigned CAP_AIR_HI = 11;
  localparam int unsigned CAP_DSUM   = 12;

  typedef logic [NUM_CAP-1:0][CNT_W-1:0] cap_pos_t;
  localparam cap_pos_t CAP_POS = {
    8'd48, 8'd37, 8'd36, 8'd35, 8'd34, 8'd32, 8'd30,
    8'd26, 8'd24, 8'd23, 8'd22, 8'd20, 8'd8
  };

  // Link modes.
  localparam logic [1:0] MODE_CONNECT = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_CONNECTED = 3'd0;
  localparam logic [2:0] ST_NO_ACK    = 3'd1;
  localparam logic [2:0] ST_DATA_OK   = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_SUM_BAD   = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;
  localparam logic [2:0] ST_ERR_MODE  = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  typedef logic [NUM_CAP-1:0][7:0] cap_arr_t;

  // One finished frame as handed from front to back.
  typedef struct packed {
    logic             over;
    logic             sum_ok;
    logic [CNT_W-1:0] len;
    logic [7:0]       data_sum;
    cap_arr_t         caps;
  } frame_rec_t;

endpackage

// ===== sv/ecu_response_frame_decoder_core.sv =====
// Response frame decoder: one result per frame. The record is written into the
// queue on the edge that accepts the final byte and decoded into the output
// register on a later edge, once the back part pops it. Throughput: one byte per cycle
// while the queue has room; one result per cycle while the output is not stalled. The four-entry
// record queue absorbs output stalls before the byte input is held off.
// Reset (rst_ni low, asynchronous): link mode to connecting, frame state cleared.
`timescale 1ns / 1ps

module ecu_response_frame_decoder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // byte input
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] rx_byte
  input  logic         s_axis_tlast_i,   // frame_last
  // result output
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [2:0] status, [4:3] link_mode, [12:5] frame_length, [20:13] coolant_temp,
  // [28:21] throttle_pct, [42:29] engine_rpm, [50:43] idle_valve_pos,
  // [61:51] supply_centivolts, [80:62] injector_us, [96:81] air_mass_tenths,
  // [107:97] lambda_mv, [111:108] zero
  output logic [111:0] m_axis_tdata_o
);

  logic                 push;
  logic                 q_not_full;
  logic                 q_not_empty;
  logic                 pop;
  erfd_pkg::frame_rec_t push_rec;
  erfd_pkg::frame_rec_t pop_rec;

  // Front: count bytes, run the checksums, capture the fixed byte slots.
  erfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .rx_byte_i    (s_axis_tdata_i),
    .frame_last_i (s_axis_tlast_i),
    .rec_ready_i  (q_not_full),
    .rec_valid_o  (push),
    .rec_o        (push_rec)
  );

  // Hold finished frames so front and back stall independently.
  erfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_rec_i  (push_rec),
    .not_full_o  (q_not_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .pop_rec_o   (pop_rec)
  );

  // Back: classify, advance the link mode, decode and register the result.
  erfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_not_empty),
    .rec_i       (pop_rec),
    .rec_pop_o   (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== sv/erfd_front.sv =====
// Front part: accepts frame bytes, keeps running sums and captures.
// Emits one frame record per final byte. Depends on erfd_pkg.
`timescale 1ns / 1ps

module erfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_last_i,
  input  logic                rec_ready_i,
  output logic                rec_valid_o,
  output erfd_pkg::frame_rec_t rec_o
);

  logic [erfd_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic [7:0]                 fsum_q, fsum_d, fsum_n;
  logic [7:0]                 dsum_q, dsum_d, dsum_n;
  logic                       over_q, over_d, over_n;
  erfd_pkg::cap_arr_t         caps_q, caps_d, caps_n;
  logic                       accept;

  assign byte_ready_o = rec_ready_i;
  assign accept       = byte_valid_i & rec_ready_i;
  assign rec_valid_o  = accept & frame_last_i;

  always_comb begin
    cnt_n  = cnt_q;
    dsum_n = dsum_q;
    over_n = over_q;
    caps_n = caps_q;
    fsum_n = fsum_q + rx_byte_i;
    if (cnt_q >= erfd_pkg::MAX_FRAME_C) begin
      over_n = 1'b1;
    end else begin
      for (int k = 0; k < erfd_pkg::NUM_CAP; k++) begin
        if (cnt_q == erfd_pkg::CAP_POS[k]) begin
          caps_n[k] = rx_byte_i;
        end
      end
      if (cnt_q >= erfd_pkg::DSUM_FIRST && cnt_q < erfd_pkg::DSUM_END) begin
        dsum_n = dsum_q + rx_byte_i;
      end
      cnt_n = cnt_q + 1'b1;
    end

    rec_o.over     = over_n;
    rec_o.sum_ok   = (rx_byte_i == fsum_q);
    rec_o.len      = cnt_n;
    rec_o.data_sum = dsum_n;
    rec_o.caps     = caps_n;

    cnt_d  = cnt_q;
    fsum_d = fsum_q;
    dsum_d = dsum_q;
    over_d = over_q;
    caps_d = caps_q;
    if (accept) begin
      if (frame_last_i) begin
        // drop all per-frame state after the final byte
        cnt_d  = '0;
        fsum_d = '0;
        dsum_d = '0;
        over_d = 1'b0;
        caps_d = '0;
      end else begin
        cnt_d  = cnt_n;
        fsum_d = fsum_n;
        dsum_d = dsum_n;
        over_d = over_n;
        caps_d = caps_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fsum_q <= '0;
      dsum_q <= '0;
      over_q <= 1'b0;
      caps_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      fsum_q <= fsum_d;
      dsum_q <= dsum_d;
      over_q <= over_d;
      caps_q <= caps_d;
    end
  end

endmodule

// ===== sv/erfd_fifo.sv =====
// Short queue of frame records between front and back.
// Depends on erfd_pkg.
`timescale 1ns / 1ps

module erfd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  erfd_pkg::frame_rec_t push_rec_i,
  output logic                 not_full_o,
  input  logic                 pop_i,
  output logic                 not_empty_o,
  output erfd_pkg::frame_rec_t pop_rec_o
);

  erfd_pkg::frame_rec_t            mem_q [erfd_pkg::QDEPTH];
  logic [erfd_pkg::QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [erfd_pkg::QPTR_W:0]       cnt_q, cnt_d;

  assign not_full_o  = (cnt_q != (erfd_pkg::QPTR_W+1)'(erfd_pkg::QDEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign pop_rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/erfd_back.sv =====
// Back part: classifies each frame record, tracks the link mode and
// decodes engine values into a registered result. Depends on erfd_pkg.
`timescale 1ns / 1ps

module erfd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rec_valid_i,
  input  erfd_pkg::frame_rec_t          rec_i,
  output logic                          rec_pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [erfd_pkg::OUT_W-1:0]    res_data_o
);

  logic [1:0]                   mode_q, mode_d;
  logic                         vld_q, vld_d;
  logic [erfd_pkg::OUT_W-1:0]   data_q, data_d;

  logic [2:0]  status;
  logic        decode;
  logic [7:0]  temp;
  logic [13:0] rpm;
  logic [10:0] supply;
  logic [18:0] inj;
  logic [15:0] air;
  logic [18:0] lam_prod;
  logic [10:0] lam;
  erfd_pkg::cap_arr_t c;

  assign c           = rec_i.caps;
  assign rec_pop_o   = rec_valid_i & (~vld_q | res_ready_i);
  assign res_valid_o = vld_q;
  assign res_data_o  = data_q;

  always_comb begin
    mode_d = mode_q;
    decode = 1'b0;
    if (rec_i.over) begin
      status = erfd_pkg::ST_OVERFLOW;
    end else if (rec_i.len < erfd_pkg::MIN_LEN) begin
      status = erfd_pkg::ST_SHORT;
    end else if (!rec_i.sum_ok) begin
      status = erfd_pkg::ST_SUM_BAD;
    end else if (mode_q == erfd_pkg::MODE_CONNECT) begin
      if (rec_i.len >= erfd_pkg::ACK_MIN_LEN &&
          c[erfd_pkg::CAP_ACK] == erfd_pkg::ACK_BYTE) begin
        status = erfd_pkg::ST_CONNECTED;
        // advance the mode only when the record is actually consumed
        if (rec_pop_o) begin
          mode_d = erfd_pkg::MODE_READ;
        end
      end else begin
        status = erfd_pkg::ST_NO_ACK;
      end
    end else if (mode_q == erfd_pkg::MODE_READ) begin
      if (rec_i.len < erfd_pkg::DATA_MIN_LEN ||
          c[erfd_pkg::CAP_DSUM] != rec_i.data_sum) begin
        status = erfd_pkg::ST_INVALID;
      end else begin
        status = erfd_pkg::ST_DATA_OK;
        decode = 1'b1;
      end
    end else begin
      status = erfd_pkg::ST_ERR_MODE;
    end

    // fixed-point decode of the engine fields
    temp     = c[erfd_pkg::CAP_TEMP] - erfd_pkg::TEMP_OFFSET;
    rpm      = (c[erfd_pkg::CAP_THR] == 8'd0) ? 14'(c[erfd_pkg::CAP_IDLE]) * 14'd10
                                              : 14'(c[erfd_pkg::CAP_LOAD]) * 14'd40;
    supply   = 11'd520 + 11'(c[erfd_pkg::CAP_BATT]) * 11'd5;
    inj      = {c[erfd_pkg::CAP_INJ_HI], c[erfd_pkg::CAP_INJ_LO], 3'b000};
    air      = {c[erfd_pkg::CAP_AIR_HI], c[erfd_pkg::CAP_AIR_LO]};
    lam_prod = 19'(c[erfd_pkg::CAP_LAMBDA]) * 19'd1250;
    lam      = lam_prod[18:8];

    vld_d  = vld_q;
    data_d = data_q;
    if (rec_pop_o) begin
      vld_d  = 1'b1;
      data_d = '0;
      data_d[2:0]  = status;
      data_d[4:3]  = mode_d;
      data_d[12:5] = rec_i.len;
      if (decode) begin
        data_d[20:13]  = temp;
        data_d[28:21]  = c[erfd_pkg::CAP_THR];
        data_d[42:29]  = rpm;
        data_d[50:43]  = c[erfd_pkg::CAP_VALVE];
        data_d[61:51]  = supply;
        data_d[80:62]  = inj;
        data_d[96:81]  = air;
        data_d[107:97] = lam;
      end
    end else if (res_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= erfd_pkg::MODE_CONNECT;
      vld_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== tb/sv/tb_ecu_response_frame_decoder_core.sv =====
// Self-checking bench for ecu_response_frame_decoder_core: streams response frames byte by byte,
// predicts each frame's result in a scoreboard class and compares every result field.
// Depends on erfd_pkg (status and mode codes, frame size limit) and the decoder RTL.
`timescale 1ns / 1ps

module tb_ecu_response_frame_decoder_core;

  // Frame rules as this bench sees them; kept apart from the package thresholds.
  localparam int unsigned MIN_FRAME_LEN = 5;
  localparam int unsigned ACK_FRAME_LEN = 9;
  localparam int unsigned DATA_LEN      = 49;
  localparam int unsigned DSUM_LO       = 6;
  localparam int unsigned DSUM_HI       = 48;
  localparam logic [7:0]  ACK_CODE      = 8'hC1;
  localparam logic [7:0]  TEMP_SUB      = 8'd40;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // Result word, lowest field last.
  typedef struct packed {
    logic [3:0]        pad;
    logic [10:0]       lambda_mv;
    logic [15:0]       air_mass_tenths;
    logic [18:0]       injector_us;
    logic [10:0]       supply_centivolts;
    logic [7:0]        idle_valve_pos;
    logic [13:0]       engine_rpm;
    logic [7:0]        throttle_pct;
    logic signed [7:0] coolant_temp;
    logic [7:0]        frame_length;
    logic [1:0]        link_mode;
    logic [2:0]        status;
  } result_t;

  typedef enum {FR_GOOD, FR_ACK, FR_NOACK, FR_DSUM_BAD, FR_FSUM_BAD, FR_NOISE} frame_kind_e;
  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  // Tracks the link the way the decoder should and queues one result per frame.
  class frame_decode_sb;
    logic [1:0] link_mode;
    logic [7:0] byte_cnt, run_sum, pay_sum;
    logic [7:0] ack_b, temp_b, thr_b, load_b, idle_b, valve_b, batt_b, lambda_b;
    logic [7:0] inj_lo, inj_hi, air_lo, air_hi, dsum_b;
    bit         overflowed;
    result_t    expected_results[$];
    int unsigned mismatches;

    function new();
      link_mode  = erfd_pkg::MODE_CONNECT;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_cnt = '0; run_sum = '0; pay_sum = '0; overflowed = 1'b0;
      ack_b = '0; temp_b = '0; thr_b = '0; load_b = '0; idle_b = '0; valve_b = '0;
      batt_b = '0; lambda_b = '0; inj_lo = '0; inj_hi = '0; air_lo = '0; air_hi = '0;
      dsum_b = '0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Called for every accepted response byte.
    function void take_byte(logic [7:0] b, logic last);
      logic sum_ok;
      if (byte_cnt >= erfd_pkg::MAX_FRAME) begin
        overflowed = 1'b1;
      end else begin
        // byte positions of the fields that the decoder keeps
        case (byte_cnt)
          8'd8:  ack_b    = b;
          8'd20: temp_b   = b;
          8'd22: thr_b    = b;
          8'd23: load_b   = b;
          8'd24: idle_b   = b;
          8'd26: valve_b  = b;
          8'd30: batt_b   = b;
          8'd32: lambda_b = b;
          8'd34: inj_lo   = b;
          8'd35: inj_hi   = b;
          8'd36: air_lo   = b;
          8'd37: air_hi   = b;
          8'd48: dsum_b   = b;
          default: ;
        endcase
        if (byte_cnt >= DSUM_LO && byte_cnt < DSUM_HI) pay_sum += b;
        byte_cnt++;
      end
      sum_ok = (b == run_sum);
      run_sum += b;
      if (last) begin
        expected_results.push_back(decode_frame(sum_ok));
        clear_frame();
      end
    endfunction

    function result_t decode_frame(logic sum_ok);
      result_t r;
      r = '0;
      if (overflowed) begin
        r.status = erfd_pkg::ST_OVERFLOW;
      end else if (byte_cnt < MIN_FRAME_LEN) begin
        r.status = erfd_pkg::ST_SHORT;
      end else if (!sum_ok) begin
        r.status = erfd_pkg::ST_SUM_BAD;
      end else if (link_mode == erfd_pkg::MODE_CONNECT) begin
        if (byte_cnt >= ACK_FRAME_LEN && ack_b == ACK_CODE) begin
          link_mode = erfd_pkg::MODE_READ;
          r.status  = erfd_pkg::ST_CONNECTED;
        end else begin
          r.status = erfd_pkg::ST_NO_ACK;
        end
      end else if (link_mode == erfd_pkg::MODE_READ) begin
        if (byte_cnt < DATA_LEN || dsum_b != pay_sum) begin
          r.status = erfd_pkg::ST_INVALID;
        end else begin
          r.status            = erfd_pkg::ST_DATA_OK;
          r.coolant_temp      = temp_b - TEMP_SUB;
          r.throttle_pct      = thr_b;
          r.engine_rpm        = (thr_b == 8'd0) ? 14'(int'(idle_b) * 10)
                                                : 14'(int'(load_b) * 40);
          r.idle_valve_pos    = valve_b;
          r.supply_centivolts = 11'(520 + int'(batt_b) * 5);
          r.injector_us       = 19'(int'({inj_hi, inj_lo}) * 8);
          r.air_mass_tenths   = {air_hi, air_lo};
          r.lambda_mv         = 11'((int'(lambda_b) * 1250) >> 8);
        end
      end else begin
        r.status = erfd_pkg::ST_ERR_MODE;
      end
      r.link_mode    = link_mode;
      r.frame_length = byte_cnt;
      return r;
    endfunction

    function void cmp(string name, integer want, integer got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Called for every accepted result word.
    function void check_result(logic [111:0] data);
      result_t got, want;
      got = data;
      if (expected_results.size() == 0) begin
        $error("status: expected no result, got %0d", got.status);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      cmp("status", want.status, got.status);
      cmp("link_mode", want.link_mode, got.link_mode);
      cmp("frame_length", want.frame_length, got.frame_length);
      cmp("coolant_temp", want.coolant_temp, got.coolant_temp);
      cmp("throttle_pct", want.throttle_pct, got.throttle_pct);
      cmp("engine_rpm", want.engine_rpm, got.engine_rpm);
      cmp("idle_valve_pos", want.idle_valve_pos, got.idle_valve_pos);
      cmp("supply_centivolts", want.supply_centivolts, got.supply_centivolts);
      cmp("injector_us", want.injector_us, got.injector_us);
      cmp("air_mass_tenths", want.air_mass_tenths, got.air_mass_tenths);
      cmp("lambda_mv", want.lambda_mv, got.lambda_mv);
      cmp("pad", want.pad, got.pad);
    endfunction
  endclass

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i  = 8'd0;
  logic         s_axis_tlast_i  = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;

  frame_decode_sb frame_sb;
  logic [7:0]     frame_bytes[$];
  int unsigned    idle_pct   = 0;
  int unsigned    stall_pct  = 0;
  int unsigned    bytes_sent = 0;
  int unsigned    frames_sent = 0;
  int unsigned    cycle_cnt  = 0;

  ecu_response_frame_decoder_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stall at random, re-rolled every falling edge.
  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= stall_pct);
  end

  // Check accepted results and guard against a hang.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) frame_sb.check_result(m_axis_tdata_o);
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL ecu_response_frame_decoder_core");
      $finish;
    end
  end

  // Fill frame_bytes with one frame of the given kind; fix up the sums last.
  function automatic void build_frame(frame_kind_e kind, int unsigned len, fill_e fill);
    logic [7:0] acc;
    int unsigned i;
    frame_bytes.delete();
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes.push_back(8'h00);
        FILL_ONES: frame_bytes.push_back(8'hFF);
        default:   frame_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
    if (kind == FR_NOISE) return;
    // idle rpm path needs throttle at zero
    if (fill == FILL_RAND && len > 22 && $urandom_range(2) == 0) frame_bytes[22] = 8'h00;
    if (len > 8) begin
      if (kind == FR_ACK) frame_bytes[8] = ACK_CODE;
      else if (kind == FR_NOACK && frame_bytes[8] == ACK_CODE) frame_bytes[8] = 8'hC0;
    end
    // nine-byte acknowledge: the final byte is both the sum and the ack code
    if (kind == FR_ACK && len == ACK_FRAME_LEN) begin
      acc = '0;
      for (i = 0; i < 7; i++) acc += frame_bytes[i];
      frame_bytes[7] = ACK_CODE - acc;
    end
    if (len >= DATA_LEN) begin
      // 49-byte frame: data sum byte is also the final byte, so zero the head sum
      if (len == DATA_LEN) begin
        acc = '0;
        for (i = 0; i < 5; i++) acc += frame_bytes[i];
        frame_bytes[5] = 8'd0 - acc;
      end
      acc = '0;
      for (i = DSUM_LO; i < DSUM_HI; i++) acc += frame_bytes[i];
      if (kind == FR_DSUM_BAD) acc += 8'($urandom_range(1, 255));
      frame_bytes[DSUM_HI] = acc;
    end
    acc = '0;
    for (i = 0; i + 1 < len; i++) acc += frame_bytes[i];
    if (kind == FR_FSUM_BAD) acc += 8'($urandom_range(1, 255));
    frame_bytes[len-1] = acc;
  endfunction

  // Drive one response byte; hold it until accepted.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    frame_sb.take_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_frame(frame_kind_e kind, int unsigned len, fill_e fill);
    int unsigned i;
    build_frame(kind, len, fill);
    for (i = 0; i < len; i++) send_byte(frame_bytes[i], i == len - 1);
    frames_sent++;
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (frame_sb.pending() != 0) @(negedge clk_i);
  endtask

  // Random frame in read-data mode: half of them well-formed data frames.
  task automatic put_random_frame();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50)
      put_frame(FR_GOOD, ($urandom_range(9) == 0) ? $urandom_range(65, 128)
                                                  : $urandom_range(49, 64), FILL_RAND);
    else if (roll < 60) put_frame(FR_DSUM_BAD, $urandom_range(50, 64), FILL_RAND);
    else if (roll < 70) put_frame(FR_FSUM_BAD, $urandom_range(1, 64), FILL_RAND);
    else if (roll < 80) put_frame(FR_GOOD, $urandom_range(5, 48), FILL_RAND);
    else if (roll < 86) put_frame(FR_GOOD, $urandom_range(1, 4), FILL_RAND);
    else if (roll < 91) put_frame(FR_NOISE, $urandom_range(129, 136), FILL_RAND);
    else put_frame(FR_NOISE, $urandom_range(1, 64), FILL_RAND);
  endtask

  initial begin
    int unsigned ph, byte_mark, frame_mark;
    frame_sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Connecting mode: short, bad sum, no acknowledge, overflow, then connect.
    put_frame(FR_GOOD, 1, FILL_RAND);
    put_frame(FR_GOOD, 4, FILL_RAND);
    put_frame(FR_FSUM_BAD, 5, FILL_RAND);
    put_frame(FR_GOOD, 5, FILL_RAND);
    put_frame(FR_ACK, 8, FILL_RAND);
    put_frame(FR_NOACK, 10, FILL_RAND);
    put_frame(FR_NOISE, 129, FILL_RAND);
    put_frame(FR_GOOD, 128, FILL_ONES);
    put_frame(FR_ACK, 9, FILL_RAND);
    // Read-data mode: data checks, extremes of the decoded fields, length limits.
    put_frame(FR_GOOD, 20, FILL_RAND);
    put_frame(FR_GOOD, 48, FILL_RAND);
    put_frame(FR_GOOD, 49, FILL_RAND);
    put_frame(FR_GOOD, 50, FILL_ZERO);
    put_frame(FR_GOOD, 60, FILL_ONES);
    put_frame(FR_DSUM_BAD, 60, FILL_RAND);
    put_frame(FR_FSUM_BAD, 60, FILL_RAND);
    put_frame(FR_ACK, 12, FILL_RAND);
    put_frame(FR_GOOD, 128, FILL_RAND);
    put_frame(FR_GOOD, 129, FILL_RAND);
    put_frame(FR_GOOD, 3, FILL_RAND);
    wait_drained();

    // Random frames under four idle/stall mixes; drain between mixes.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      byte_mark  = bytes_sent;
      frame_mark = frames_sent;
      while (bytes_sent - byte_mark < 100 || frames_sent - frame_mark < 3) put_random_frame();
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (20) @(posedge clk_i);
    if (frame_sb.mismatches == 0 && frame_sb.pending() == 0)
      $display("PASS ecu_response_frame_decoder_core");
    else
      $display("FAIL ecu_response_frame_decoder_core");
    $finish;
  end

endmodule
